FILE: sv/imu_six_axis_conditioner_defines.svh
// assertion macros for the imu six-axis conditioner
// no dependencies; included by the top level ahead of its checks
`ifndef IMU_SIX_AXIS_CONDITIONER_DEFINES_SVH
`define IMU_SIX_AXIS_CONDITIONER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define IMUC_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("imuc check failed: same-cycle implication");

`define IMUC_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("imuc check failed: next-cycle implication");

`else

`define IMUC_ASSERT_IMP(name, pre, post)

`define IMUC_ASSERT_NXT(name, pre, post)

`endif

`endif

FILE: sv/imuc_pkg.sv
// shared types, sizes and constants for the imu six-axis conditioner
// no dependencies; used by every module of the block
`default_nettype none

package imuc_pkg;

    localparam int WINDOW   = 10;
    localparam int AXES     = 6;
    localparam int SAMPLE_W = 16;
    localparam int WP_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // a window sum of int16 values fits in 16 + clog2(WINDOW) signed bits
    localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);
    localparam int SUMX_W    = SUM_W + 2;
    localparam int MAG_W     = SUM_W;
    localparam int DIV_SHIFT = MAG_W + $clog2(WINDOW);
    localparam int RECIP_W   = MAG_W + 1;
    localparam int PROD_W    = MAG_W + RECIP_W;

    // ceil(2^DIV_SHIFT / WINDOW): exact floor division for every magnitude below 2^MAG_W
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SHIFT) +
        64'(WINDOW) - 64'd1) / 64'(WINDOW));

    localparam logic [WP_W-1:0] WP_LAST = WP_W'(WINDOW - 1);

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX   = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN   = 16'sh8000;
    localparam logic        [SAMPLE_W:0]   MID_LEVEL = 17'd32767;

    // configuration port
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_GYRO_X_OFF = 2'd0;
    localparam logic [1:0] REG_GYRO_Y_OFF = 2'd1;
    localparam logic [1:0] REG_GYRO_Z_OFF = 2'd2;

    // axis slots inside a sample vector
    localparam int AX_GX = 0;
    localparam int AX_GY = 1;
    localparam int AX_GZ = 2;
    localparam int AX_AX = 3;
    localparam int AX_AY = 4;
    localparam int AX_AZ = 5;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [AXES-1:0] sample_vec_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef sum_t [AXES-1:0] sum_vec_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] gyro_x_offset;
        logic [SAMPLE_W-1:0] gyro_y_offset;
        logic [SAMPLE_W-1:0] gyro_z_offset;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_gyro_x;
        logic [SAMPLE_W-1:0] raw_gyro_y;
        logic [SAMPLE_W-1:0] raw_gyro_z;
        logic [SAMPLE_W-1:0] raw_accel_x;
        logic [SAMPLE_W-1:0] raw_accel_y;
        logic [SAMPLE_W-1:0] raw_accel_z;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] gyro_x_now;
        logic signed [SAMPLE_W-1:0] gyro_y_now;
        logic signed [SAMPLE_W-1:0] gyro_z_now;
        logic signed [SAMPLE_W-1:0] accel_x_now;
        logic signed [SAMPLE_W-1:0] accel_y_now;
        logic signed [SAMPLE_W-1:0] accel_z_now;
        logic signed [SAMPLE_W-1:0] gyro_x_mean;
        logic signed [SAMPLE_W-1:0] gyro_y_mean;
        logic signed [SAMPLE_W-1:0] gyro_z_mean;
        logic signed [SAMPLE_W-1:0] accel_x_mean;
        logic signed [SAMPLE_W-1:0] accel_y_mean;
        logic signed [SAMPLE_W-1:0] accel_z_mean;
    } out_word_t;

endpackage

`default_nettype wire

FILE: sv/imuc_cond.sv
// per-scan conditioning: offset removal, gyro y/z negation, accel flip, saturation
// depends on imuc_pkg
`default_nettype none

module imuc_cond (
    input  var imuc_pkg::in_word_t    raw,
    input  var imuc_pkg::cfg_t        cfg,
    output imuc_pkg::sample_vec_t     now
);

    logic signed [imuc_pkg::SAMPLE_W:0] diff_gx;
    logic signed [imuc_pkg::SAMPLE_W:0] diff_gy;
    logic signed [imuc_pkg::SAMPLE_W:0] diff_gz;
    logic        [imuc_pkg::SAMPLE_W:0] acc_x;
    logic        [imuc_pkg::SAMPLE_W:0] acc_y;
    logic        [imuc_pkg::SAMPLE_W:0] acc_z;

    function automatic imuc_pkg::sample_t sat16(input logic signed [imuc_pkg::SAMPLE_W:0] d);
        imuc_pkg::sample_t r;
        if (d[imuc_pkg::SAMPLE_W] != d[imuc_pkg::SAMPLE_W-1]) begin
            r = d[imuc_pkg::SAMPLE_W] ? imuc_pkg::SAT_MIN : imuc_pkg::SAT_MAX;
        end else begin
            r = d[imuc_pkg::SAMPLE_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        diff_gx = $signed({1'b0, raw.raw_gyro_x}) - $signed({1'b0, cfg.gyro_x_offset});
        diff_gy = $signed({1'b0, cfg.gyro_y_offset}) - $signed({1'b0, raw.raw_gyro_y});
        diff_gz = $signed({1'b0, cfg.gyro_z_offset}) - $signed({1'b0, raw.raw_gyro_z});
        // mid level minus raw always lands in int16 range
        acc_x = imuc_pkg::MID_LEVEL - {1'b0, raw.raw_accel_x};
        acc_y = imuc_pkg::MID_LEVEL - {1'b0, raw.raw_accel_y};
        acc_z = imuc_pkg::MID_LEVEL - {1'b0, raw.raw_accel_z};

        now[imuc_pkg::AX_GX] = sat16(diff_gx);
        now[imuc_pkg::AX_GY] = sat16(diff_gy);
        now[imuc_pkg::AX_GZ] = sat16(diff_gz);
        now[imuc_pkg::AX_AX] = acc_x[imuc_pkg::SAMPLE_W-1:0];
        now[imuc_pkg::AX_AY] = acc_y[imuc_pkg::SAMPLE_W-1:0];
        now[imuc_pkg::AX_AZ] = acc_z[imuc_pkg::SAMPLE_W-1:0];
    end

endmodule

`default_nettype wire

FILE: sv/imuc_mean.sv
// window sum to mean: divide by the window length, truncating toward zero
// depends on imuc_pkg; one reciprocal multiplier per axis, no correction step needed
`default_nettype none

module imuc_mean (
    input  var imuc_pkg::sum_vec_t    sums,
    output imuc_pkg::sample_vec_t     means
);

    logic                             neg  [imuc_pkg::AXES];
    logic [imuc_pkg::MAG_W-1:0]       mag  [imuc_pkg::AXES];
    logic [imuc_pkg::PROD_W-1:0]      prod [imuc_pkg::AXES];
    logic [imuc_pkg::SAMPLE_W-1:0]    quo  [imuc_pkg::AXES];

    always_comb begin
        for (int a = 0; a < imuc_pkg::AXES; a++) begin
            neg[a]   = sums[a][imuc_pkg::SUM_W-1];
            mag[a]   = neg[a] ? imuc_pkg::MAG_W'(-sums[a]) : imuc_pkg::MAG_W'(sums[a]);
            prod[a]  = imuc_pkg::PROD_W'(mag[a]) * imuc_pkg::PROD_W'(imuc_pkg::RECIP);
            // quotient magnitude never exceeds 32768
            quo[a]   = prod[a][imuc_pkg::DIV_SHIFT +: imuc_pkg::SAMPLE_W];
            means[a] = neg[a] ? imuc_pkg::sample_t'(-quo[a]) : imuc_pkg::sample_t'(quo[a]);
        end
    end

endmodule

`default_nettype wire

FILE: sv/imu_six_axis_conditioner.sv
// imu six-axis conditioner: conditions one scan per word and keeps a boxcar mean per axis
// m_valid rises once an accepted word passes the stage 1, stage 2 and output registers
// throughput: one scan per cycle unless m_ready stalls, set by one ram read and write-back
// the registered history ram read feeds a running-sum register per axis
// reset: offsets and running sums go to zero, history valid bits clear at once
// (unwritten history entries count as zero, no clearing pass)
`default_nettype none

module imu_six_axis_conditioner (
    input  wire                               aclk,
    input  wire                               aresetn,
    // configuration
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [imuc_pkg::ADDR_W-1:0]       paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // scans in
    input  wire                               s_valid,
    output logic                              s_ready,
    input  var   imuc_pkg::in_word_t          s_data,
    // results out
    output logic                              m_valid,
    input  wire                               m_ready,
    output imuc_pkg::out_word_t               m_data
);

    imuc_pkg::cfg_t                   cfg_reg;
    logic                             cfg_wr;

    logic [imuc_pkg::WP_W-1:0]        wp_reg;
    logic [imuc_pkg::WP_W-1:0]        wp_next;
    logic [imuc_pkg::WINDOW-1:0]      hist_valid_reg;
    imuc_pkg::sample_vec_t            hist_mem [imuc_pkg::WINDOW];
    imuc_pkg::sample_vec_t            hist_rd_reg;

    imuc_pkg::sample_vec_t            now_in;
    logic                             accept;

    logic                             s1_v_reg;
    imuc_pkg::sample_vec_t            s1_now_reg;
    logic [imuc_pkg::WP_W-1:0]        s1_wp_reg;
    logic                             s1_old_ok_reg;
    logic                             s1_move;

    imuc_pkg::sum_vec_t               sum_reg;
    imuc_pkg::sum_vec_t               sum_next;

    logic                             s2_v_reg;
    imuc_pkg::sample_vec_t            s2_now_reg;
    imuc_pkg::sum_vec_t               s2_sum_reg;
    imuc_pkg::sample_vec_t            mean_vec;

    logic                             m_valid_reg;
    imuc_pkg::out_word_t              m_data_reg;
    imuc_pkg::out_word_t              m_data_next;

    logic                             out_adv;
    logic                             s2_adv;
    logic                             s1_adv;

    // ---------------- configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                imuc_pkg::REG_GYRO_X_OFF: cfg_reg.gyro_x_offset <= pwdata[15:0];
                imuc_pkg::REG_GYRO_Y_OFF: cfg_reg.gyro_y_offset <= pwdata[15:0];
                imuc_pkg::REG_GYRO_Z_OFF: cfg_reg.gyro_z_offset <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            imuc_pkg::REG_GYRO_X_OFF: prdata = {16'b0, cfg_reg.gyro_x_offset};
            imuc_pkg::REG_GYRO_Y_OFF: prdata = {16'b0, cfg_reg.gyro_y_offset};
            imuc_pkg::REG_GYRO_Z_OFF: prdata = {16'b0, cfg_reg.gyro_z_offset};
            default:                  prdata = 32'b0;
        endcase
    end

    // ---------------- pipeline flow, bubbles collapse
    assign out_adv = ~m_valid_reg | m_ready;
    assign s2_adv  = ~s2_v_reg | out_adv;
    assign s1_adv  = ~s1_v_reg | s2_adv;
    assign s_ready = s1_adv;
    assign accept  = s_valid & s_ready;
    assign s1_move = s1_v_reg & s2_adv;

    // ---------------- stage 0: condition and issue the history read
    imuc_cond u_cond (
        .raw (s_data),
        .cfg (cfg_reg),
        .now (now_in)
    );

    assign wp_next = (wp_reg == imuc_pkg::WP_LAST) ? '0 : wp_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            s1_v_reg <= 1'b0;
        end else begin
            if (accept) begin
                wp_reg <= wp_next;
            end
            if (s1_adv) begin
                s1_v_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_now_reg    <= now_in;
            s1_wp_reg     <= wp_reg;
            s1_old_ok_reg <= hist_valid_reg[wp_reg];
        end
    end

    // history ram: read at the new word's slot, write back the word leaving stage 1;
    // the two slots always differ since consecutive words take consecutive slots
    always_ff @(posedge aclk) begin
        if (accept) begin
            hist_rd_reg <= hist_mem[wp_reg];
        end
        if (s1_move) begin
            hist_mem[s1_wp_reg] <= s1_now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_valid_reg <= '0;
        end else if (s1_move) begin
            hist_valid_reg[s1_wp_reg] <= 1'b1;
        end
    end

    // ---------------- stage 1: running sum update
    always_comb begin
        logic signed [imuc_pkg::SUMX_W-1:0] acc;
        imuc_pkg::sample_t                  old;
        for (int a = 0; a < imuc_pkg::AXES; a++) begin
            old = s1_old_ok_reg ? hist_rd_reg[a] : '0;
            acc = imuc_pkg::SUMX_W'(sum_reg[a]) + imuc_pkg::SUMX_W'(s1_now_reg[a])
                - imuc_pkg::SUMX_W'(old);
            sum_next[a] = acc[imuc_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            s2_v_reg <= 1'b0;
        end else begin
            if (s1_move) begin
                sum_reg <= sum_next;
            end
            if (s2_adv) begin
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_now_reg <= s1_now_reg;
            s2_sum_reg <= sum_next;
        end
    end

    // ---------------- stage 2: mean and output register
    imuc_mean u_mean (
        .sums  (s2_sum_reg),
        .means (mean_vec)
    );

    always_comb begin
        m_data_next.gyro_x_now   = s2_now_reg[imuc_pkg::AX_GX];
        m_data_next.gyro_y_now   = s2_now_reg[imuc_pkg::AX_GY];
        m_data_next.gyro_z_now   = s2_now_reg[imuc_pkg::AX_GZ];
        m_data_next.accel_x_now  = s2_now_reg[imuc_pkg::AX_AX];
        m_data_next.accel_y_now  = s2_now_reg[imuc_pkg::AX_AY];
        m_data_next.accel_z_now  = s2_now_reg[imuc_pkg::AX_AZ];
        m_data_next.gyro_x_mean  = mean_vec[imuc_pkg::AX_GX];
        m_data_next.gyro_y_mean  = mean_vec[imuc_pkg::AX_GY];
        m_data_next.gyro_z_mean  = mean_vec[imuc_pkg::AX_GZ];
        m_data_next.accel_x_mean = mean_vec[imuc_pkg::AX_AX];
        m_data_next.accel_y_mean = mean_vec[imuc_pkg::AX_AY];
        m_data_next.accel_z_mean = mean_vec[imuc_pkg::AX_AZ];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv & s2_v_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- checks
`include "imu_six_axis_conditioner_defines.svh"

    `IMUC_ASSERT_IMP(a_rd_wr_slot_differ, accept && s1_move, wp_reg != s1_wp_reg)
    `IMUC_ASSERT_NXT(a_rd_data_held, s1_v_reg && !s2_adv, $stable(hist_rd_reg))
    `IMUC_ASSERT_IMP(a_wp_in_window, 1'b1, wp_reg <= imuc_pkg::WP_LAST)
    `IMUC_ASSERT_NXT(a_slot_marked, s1_move, hist_valid_reg[$past(s1_wp_reg)])

endmodule

`default_nettype wire

FILE: tb/tb.sv
// self-checking bench for imu_six_axis_conditioner: a table of directed scans, then random scans
// across several offset settings, checked against a behavioral model of the boxcar filter or typed-in results
// depends on imuc_pkg and the imu_six_axis_conditioner top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imuc_pkg::*;

    localparam int        RANDOM_SCANS = 450;
    localparam int        QUIET_LIMIT  = 5000;
    localparam int        DRAIN_CYCLES = 6;
    localparam logic [1:0] REG_NONE    = 2'd3;

    typedef struct {
        cfg_t      off;
        in_word_t  scan;
        bit        typed;
        out_word_t want;
    } dir_row_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_word_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_word_t           m_data;

    int src_idle = 28;
    int snk_idle = 28;
    int fails    = 0;
    int quiet    = 0;

    // model state: offsets, ring window and its write pointer
    logic [15:0] gx_off = '0;
    logic [15:0] gy_off = '0;
    logic [15:0] gz_off = '0;
    sample_t     win_hist [WINDOW][AXES];
    int          win_pos = 0;

    out_word_t scan_results_due [$];

    string field_names [12] = '{"gyro_x_now", "gyro_y_now", "gyro_z_now",
                                "accel_x_now", "accel_y_now", "accel_z_now",
                                "gyro_x_mean", "gyro_y_mean", "gyro_z_mean",
                                "accel_x_mean", "accel_y_mean", "accel_z_mean"};

    imu_six_axis_conditioner i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        for (int k = 0; k < WINDOW; k++) begin
            for (int a = 0; a < AXES; a++) begin
                win_hist[k][a] = '0;
            end
        end
    end

    function automatic int clamp16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // conditions one scan, writes it into the window and returns the expected word
    function automatic out_word_t condition_scan(in_word_t w);
        int               cond [AXES];
        int               sum;
        logic [11:0][15:0] f;
        cond[AX_GX] = clamp16(int'(w.raw_gyro_x) - int'(gx_off));
        cond[AX_GY] = clamp16(int'(gy_off) - int'(w.raw_gyro_y));
        cond[AX_GZ] = clamp16(int'(gz_off) - int'(w.raw_gyro_z));
        cond[AX_AX] = 32767 - int'(w.raw_accel_x);
        cond[AX_AY] = 32767 - int'(w.raw_accel_y);
        cond[AX_AZ] = 32767 - int'(w.raw_accel_z);
        for (int a = 0; a < AXES; a++) begin
            win_hist[win_pos][a] = sample_t'(cond[a]);
        end
        win_pos = (win_pos + 1) % WINDOW;
        for (int a = 0; a < AXES; a++) begin
            sum = 0;
            for (int k = 0; k < WINDOW; k++) begin
                sum += int'(win_hist[k][a]);
            end
            f[11 - a] = 16'(cond[a]);
            // int division truncates toward zero
            f[5 - a]  = 16'(clamp16(sum / WINDOW));
        end
        return out_word_t'(f);
    endfunction

    function automatic logic [15:0] rand_raw(logic [15:0] pivot);
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'h7fff;
            4, 5: return pivot + 16'($urandom_range(0, 64)) - 16'd32;
            // around the saturation boundary of the difference
            6: return pivot + 16'h8000 + 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_offset();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_scan(input in_word_t w, input bit typed, input out_word_t want);
        out_word_t r;
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!(s_valid && s_ready));
        r = condition_scan(w);
        scan_results_due.push_back(typed ? want : r);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_GYRO_X_OFF: gx_off = data[15:0];
            REG_GYRO_Y_OFF: gy_off = data[15:0];
            REG_GYRO_Z_OFF: gz_off = data[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side: random back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    always @(posedge aclk) begin
        out_word_t         exp_w;
        logic [11:0][15:0] e_f;
        logic [11:0][15:0] g_f;
        if (aresetn && m_valid && m_ready) begin
            if (scan_results_due.size() == 0) begin
                $error("result word with none expected");
                fails++;
            end else begin
                exp_w = scan_results_due.pop_front();
                e_f   = exp_w;
                g_f   = m_data;
                for (int k = 0; k < 12; k++) begin
                    if (e_f[11 - k] !== g_f[11 - k]) begin
                        $error("%s: expected %0d, got %0d", field_names[k],
                               $signed(e_f[11 - k]), $signed(g_f[11 - k]));
                        fails++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        dir_row_t    dir_tab [$];
        in_word_t    w;
        int          sent;
        int          plen;
        cfg_t        off0;
        cfg_t        off_max;
        cfg_t        off_mid;
        off0    = '0;
        off_max = {3{16'hffff}};
        off_mid = {3{16'h8000}};

        // first two rows follow reset directly, so their results are typed in
        dir_tab.push_back('{off: off0, scan: {6{16'h0000}}, typed: 1'b1,
            want: {16'd0, 16'd0, 16'd0, 16'd32767, 16'd32767, 16'd32767,
                   16'd0, 16'd0, 16'd0, 16'd3276, 16'd3276, 16'd3276}});
        dir_tab.push_back('{off: off0, scan: {6{16'hffff}}, typed: 1'b1,
            want: {16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                   16'd3276, 16'hf334, 16'hf334, 16'd0, 16'd0, 16'd0}});
        dir_tab.push_back('{off: off0, typed: 1'b0, want: '0,
            scan: {16'h7fff, 16'h8000, 16'h8001, 16'h7fff, 16'h0000, 16'h8000}});
        // fill the whole window with extremes so the ring wraps
        for (int i = 0; i < WINDOW; i++) begin
            dir_tab.push_back('{off: off0, scan: {6{16'hffff}}, typed: 1'b0, want: '0});
        end
        dir_tab.push_back('{off: off_max, scan: {6{16'h0000}}, typed: 1'b0, want: '0});
        dir_tab.push_back('{off: off_max, scan: {6{16'hffff}}, typed: 1'b0, want: '0});
        dir_tab.push_back('{off: off_max, scan: {6{16'h7fff}}, typed: 1'b0, want: '0});
        dir_tab.push_back('{off: off_mid, scan: {6{16'h0000}}, typed: 1'b0, want: '0});
        dir_tab.push_back('{off: off_mid, scan: {6{16'hffff}}, typed: 1'b0, want: '0});
        dir_tab.push_back('{off: off_mid, typed: 1'b0, want: '0,
            scan: {16'h0001, 16'h7fff, 16'h8000, 16'h5555, 16'haaaa, 16'h1234}});
        dir_tab.push_back('{off: {16'h1234, 16'h5678, 16'h9abc}, typed: 1'b0, want: '0,
            scan: {16'h1234, 16'h5678, 16'h9abc, 16'hfedc, 16'h0f0f, 16'hf0f0}});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].off != {gx_off, gy_off, gz_off}) begin
                settle();
                write_reg(REG_GYRO_X_OFF, {16'h0000, dir_tab[i].off.gyro_x_offset});
                write_reg(REG_GYRO_Y_OFF, {16'h0000, dir_tab[i].off.gyro_y_offset});
                write_reg(REG_GYRO_Z_OFF, {16'h0000, dir_tab[i].off.gyro_z_offset});
            end
            push_scan(dir_tab[i].scan, dir_tab[i].typed, dir_tab[i].want);
        end
        settle();

        sent = 0;
        while (sent < RANDOM_SCANS) begin
            // upper data bits carry junk, the block keeps only the low half
            write_reg(REG_GYRO_X_OFF, {16'($urandom), pick_offset()});
            write_reg(REG_GYRO_Y_OFF, {16'($urandom), pick_offset()});
            write_reg(REG_GYRO_Z_OFF, {16'($urandom), pick_offset()});
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_NONE, $urandom);
            end
            plen = $urandom_range(20, 70);
            for (int j = 0; j < plen && sent < RANDOM_SCANS; j++) begin
                // a long stretch at full rate on both sides
                src_idle = (sent >= 150 && sent < 300) ? 0 : 28;
                snk_idle = src_idle;
                w.raw_gyro_x  = rand_raw(gx_off);
                w.raw_gyro_y  = rand_raw(gy_off);
                w.raw_gyro_z  = rand_raw(gz_off);
                w.raw_accel_x = rand_raw(16'h7fff);
                w.raw_accel_y = rand_raw(16'h7fff);
                w.raw_accel_z = rand_raw(16'h7fff);
                push_scan(w, 1'b0, '0);
                sent++;
            end
            settle();
        end

        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
